// ----- rtl/core/shg_pkg.sv -----
// shared types, constants and helpers of the spatial hash grid
package shg_pkg;

   localparam int GRID_BITS    = 6;
   localparam int KEY_W        = 2 * GRID_BITS;
   localparam int CELL_COUNT   = 1 << KEY_W;
   localparam int BUCKET_SLOTS = 4;
   localparam int SLOT_BITS    = 2;
   localparam int FILL_W       = 3;
   localparam int HANDLE_W     = 11;
   localparam int MAX_HANDLES  = 1024;
   localparam int HIDX_W       = 10;
   localparam int FRAC_BITS    = 4;
   localparam int POS_W        = 16;
   localparam int CELL_W       = POS_W - FRAC_BITS;
   localparam int COORD_W      = CELL_W + 1;
   localparam int CMP_W        = POS_W + 2;
   localparam int RANGE_W      = 5;
   localparam int TOTAL_W      = 15;
   localparam int RESULT_CAP   = 64;
   localparam int CNT_W        = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int RANGE_RESET  = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OFFGRID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXACT_FILTER = 2'd1;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [HANDLE_W-1:0]       item_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] found_handle;
      logic [1:0]          status;
      logic                last;
      logic [TOTAL_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS,
      ST_DONE,
      ST_QCELL,
      ST_QHND,
      ST_QPOS,
      ST_QEND
   } state_type;

   function automatic logic [KEY_W-1:0] morton(input logic [GRID_BITS-1:0] cx,
                                               input logic [GRID_BITS-1:0] cy);
      logic [KEY_W-1:0] key;
      key = '0;
      for (int b = 0; b < GRID_BITS; b++) begin
         key[2*b]   = cx[b];
         key[2*b+1] = cy[b];
      end
      return key;
   endfunction

endpackage

// ----- rtl/core/shg_rsp_reg.sv -----
// one-entry output register for the response channel
module shg_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  shg_pkg::rsp_type push_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shg_pkg::rsp_type rsp_data
);
   import shg_pkg::*;

   logic    full_ff;
   rsp_type data_ff;

   assign push_ready = !full_ff || rsp_ready;
   assign rsp_valid  = full_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (push_valid && push_ready) begin
         full_ff <= 1'b1;
      end else if (rsp_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

endmodule

// ----- rtl/core/spatial_hash_grid_range_query_top.sv -----
// spatial hash grid: morton-addressed buckets with range query walk
// insert: reads the cell fill and stores the entry if there is room, unless rejected up front
// query: walks up to 16 cells, reads each handle and its position, then gives a final result
// clear sweeps the fill memory; one request at a time; a full output register stalls the walk
// reset (synchronous) sweeps all 4096 cells of the fill memory before req_ready rises
// handle and position memories are undefined until written
module spatial_hash_grid_range_query_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  shg_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output shg_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [shg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [shg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import shg_pkg::*;

   state_type state_ff, state_in;
   logic [KEY_W-1:0] clr_ff, clr_in;
   logic clr_op_ff, clr_op_in;
   req_type req_ff, req_in;
   logic [1:0] status_ff, status_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COORD_W-1:0] lo_y_ff, lo_y_in, hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HANDLE_W-1:0] h_ff, h_in, pend_h_ff, pend_h_in;
   logic pend_v_ff, pend_v_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [RANGE_W-1:0] range_ff;
   logic filter_ff;

   logic [FILL_W-1:0] fill_mem [CELL_COUNT];
   logic [HANDLE_W-1:0] hnd_mem [CELL_COUNT * BUCKET_SLOTS];
   logic [2*POS_W-1:0] pos_mem [MAX_HANDLES];
   logic [FILL_W-1:0] fill_rd_ff;
   logic [HANDLE_W-1:0] hnd_rd_ff;
   logic [2*POS_W-1:0] pos_rd_ff;

   logic fill_we, hnd_we, pos_we;
   logic [KEY_W-1:0] fill_wa, fill_ra;
   logic [FILL_W-1:0] fill_wd;
   logic [KEY_W+SLOT_BITS-1:0] hnd_wa, hnd_ra;
   logic [HIDX_W-1:0] pos_wa, pos_ra;
   logic [KEY_W-1:0] walk_key;

   logic push_valid, push_ready;
   rsp_type push_data;

   logic signed [CELL_W-1:0] cx_req, cy_req;
   logic signed [COORD_W-1:0] cxe, cye;
   logic [1:0] r_up;
   logic r_dn;
   logic req_h_ok, req_cell_ok;
   logic on_grid, adv_last, slot_more;
   logic signed [CMP_W-1:0] px_c, py_c, sx_c, sy_c, r_c;
   logic in_box, h_ok, keep, take, need_push;

   assign cx_req = CELL_W'($signed(req_data.pos_x) >>> FRAC_BITS);
   assign cy_req = CELL_W'($signed(req_data.pos_y) >>> FRAC_BITS);
   assign cxe = COORD_W'(cx_req);
   assign cye = COORD_W'(cy_req);
   assign r_dn = range_ff[RANGE_W-1];
   assign r_up = {1'b0, range_ff[RANGE_W-1]} + {1'b0, (range_ff[FRAC_BITS-1:0] != '0)};
   assign req_h_ok = (req_data.item_handle != '0) &&
                     (req_data.item_handle <= HANDLE_W'(MAX_HANDLES));
   assign req_cell_ok = (cx_req[CELL_W-1:GRID_BITS] == '0) &&
                        (cy_req[CELL_W-1:GRID_BITS] == '0);

   assign on_grid = (x_ff[COORD_W-1:GRID_BITS] == '0) && (y_ff[COORD_W-1:GRID_BITS] == '0);
   assign adv_last = (x_ff == hi_x_ff) && (y_ff == hi_y_ff);
   assign slot_more = (FILL_W'(slot_ff) + FILL_W'(1)) < fill_ff;

   assign px_c = CMP_W'(req_ff.pos_x);
   assign py_c = CMP_W'(req_ff.pos_y);
   assign sx_c = CMP_W'($signed(pos_rd_ff[POS_W-1:0]));
   assign sy_c = CMP_W'($signed(pos_rd_ff[2*POS_W-1:POS_W]));
   assign r_c  = $signed({{(CMP_W-RANGE_W){1'b0}}, range_ff});
   assign in_box = !(sx_c < px_c - r_c) && !(sy_c < py_c - r_c) &&
                   !(sx_c > px_c + r_c) && !(sy_c > py_c + r_c);
   assign h_ok = (h_ff != '0) && (h_ff <= HANDLE_W'(MAX_HANDLES));
   assign keep = !filter_ff || !h_ok || in_box;
   assign take = keep && (cnt_ff < CNT_W'(RESULT_CAP));
   assign need_push = take && pend_v_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign walk_key = morton(x_ff[GRID_BITS-1:0], y_ff[GRID_BITS-1:0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == KEY_W'(CELL_COUNT - 1)) begin
               state_in = clr_op_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode)
                  OP_INSERT: state_in = (req_h_ok && req_cell_ok) ? ST_INS : ST_DONE;
                  OP_QUERY:  state_in = ST_QCELL;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_INS: state_in = ST_DONE;
         ST_DONE: begin
            if (push_ready) state_in = ST_IDLE;
         end
         ST_QCELL: begin
            if (on_grid && fill_rd_ff != '0) state_in = ST_QHND;
            else if (adv_last) state_in = ST_QEND;
         end
         ST_QHND: state_in = ST_QPOS;
         ST_QPOS: begin
            if (!(need_push && !push_ready)) begin
               if (slot_more) state_in = ST_QHND;
               else if (adv_last) state_in = ST_QEND;
               else state_in = ST_QCELL;
            end
         end
         ST_QEND: begin
            if (push_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      clr_op_in = clr_op_ff;
      req_in = req_ff;
      status_in = status_ff;
      x_in = x_ff;
      y_in = y_ff;
      lo_y_in = lo_y_ff;
      hi_x_in = hi_x_ff;
      hi_y_in = hi_y_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      h_in = h_ff;
      pend_h_in = pend_h_ff;
      pend_v_in = pend_v_ff;
      cnt_in = cnt_ff;
      total_in = total_ff;
      fill_we = 1'b0;
      fill_wa = walk_key;
      fill_wd = '0;
      hnd_we = 1'b0;
      hnd_wa = {walk_key, fill_rd_ff[SLOT_BITS-1:0]};
      pos_we = 1'b0;
      pos_wa = HIDX_W'(req_ff.item_handle - HANDLE_W'(1));
      push_valid = 1'b0;
      push_data = '{found_handle: '0, status: status_ff, last: 1'b1, entry_count: total_ff};
      case (state_ff)
         ST_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff;
            clr_in = clr_ff + KEY_W'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               status_in = STATUS_OK;
               pend_v_in = 1'b0;
               cnt_in = '0;
               case (req_data.opcode)
                  OP_INSERT: begin
                     x_in = cxe;
                     y_in = cye;
                     if (req_h_ok && !req_cell_ok) status_in = STATUS_OFFGRID;
                  end
                  OP_QUERY: begin
                     x_in = cxe - COORD_W'(r_up);
                     y_in = cye - COORD_W'(r_up);
                     lo_y_in = cye - COORD_W'(r_up);
                     hi_x_in = cxe + COORD_W'(r_dn);
                     hi_y_in = cye + COORD_W'(r_dn);
                  end
                  OP_CLEAR: begin
                     clr_in = '0;
                     clr_op_in = 1'b1;
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS: begin
            if (fill_rd_ff >= FILL_W'(BUCKET_SLOTS)) begin
               status_in = STATUS_FULL;
            end else begin
               fill_we = 1'b1;
               fill_wd = fill_rd_ff + FILL_W'(1);
               hnd_we = 1'b1;
               pos_we = 1'b1;
               total_in = total_ff + TOTAL_W'(1);
            end
         end
         ST_DONE: begin
            push_valid = 1'b1;
            if (push_ready) clr_op_in = 1'b0;
         end
         ST_QCELL: begin
            fill_in = fill_rd_ff;
            slot_in = '0;
            if (!(on_grid && fill_rd_ff != '0) && !adv_last) begin
               if (y_ff != hi_y_ff) begin
                  y_in = y_ff + COORD_W'(1);
               end else begin
                  x_in = x_ff + COORD_W'(1);
                  y_in = lo_y_ff;
               end
            end
         end
         ST_QHND: h_in = hnd_rd_ff;
         ST_QPOS: begin
            push_valid = need_push;
            push_data = '{found_handle: pend_h_ff, status: STATUS_OK, last: 1'b0,
                          entry_count: total_ff};
            if (!(need_push && !push_ready)) begin
               if (take) begin
                  pend_h_in = h_ff;
                  pend_v_in = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (slot_more) begin
                  slot_in = slot_ff + SLOT_BITS'(1);
               end else if (!adv_last) begin
                  if (y_ff != hi_y_ff) begin
                     y_in = y_ff + COORD_W'(1);
                  end else begin
                     x_in = x_ff + COORD_W'(1);
                     y_in = lo_y_ff;
                  end
               end
            end
         end
         ST_QEND: begin
            push_valid = 1'b1;
            push_data = '{found_handle: pend_v_ff ? pend_h_ff : '0, status: STATUS_OK,
                          last: 1'b1, entry_count: total_ff};
         end
         default: begin
         end
      endcase
   end

   assign fill_ra = morton(x_in[GRID_BITS-1:0], y_in[GRID_BITS-1:0]);
   assign hnd_ra = {fill_ra, slot_in};
   assign pos_ra = HIDX_W'(h_in - HANDLE_W'(1));

   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd_ff <= fill_mem[fill_ra];
   end

   always_ff @(posedge clock) begin
      if (hnd_we) hnd_mem[hnd_wa] <= req_ff.item_handle;
      hnd_rd_ff <= hnd_mem[hnd_ra];
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= {req_ff.pos_y, req_ff.pos_x};
      pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         clr_op_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         cnt_ff <= '0;
         total_ff <= '0;
         status_ff <= STATUS_OK;
         range_ff <= RANGE_W'(RANGE_RESET);
         filter_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         clr_op_ff <= clr_op_in;
         pend_v_ff <= pend_v_in;
         cnt_ff <= cnt_in;
         total_ff <= total_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEARCH_RANGE: range_ff <= csr_wdata[RANGE_W-1:0];
               CSR_EXACT_FILTER: filter_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      x_ff <= x_in;
      y_ff <= y_in;
      lo_y_ff <= lo_y_in;
      hi_x_ff <= hi_x_in;
      hi_y_ff <= hi_y_in;
      slot_ff <= slot_in;
      fill_ff <= fill_in;
      h_ff <= h_in;
      pend_h_ff <= pend_h_in;
   end

   shg_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // hit count stays within the cap
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RESULT_CAP))
      else $error("hit count above cap");

   // a non-final result is always a query hit
   a_mid_hit: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_data.last |-> push_data.found_handle != '0 &&
                                        push_data.status == STATUS_OK)
      else $error("non-final result without hit");

   // an accepted request leaves idle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("request accepted but still idle");

   // a bucket is never written past its last slot
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> fill_wd <= FILL_W'(BUCKET_SLOTS))
      else $error("bucket fill overflow");

endmodule

// ----- tb/sv/shg_checker.sv -----
// request/result monitor, grid predictor and result comparator for the spatial hash grid
`timescale 1ns / 100ps
module shg_checker
   import shg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    results_seen
);

   int               fill_count[CELL_COUNT];
   logic [HANDLE_W-1:0] bucket_handle[CELL_COUNT*BUCKET_SLOTS];
   int               handle_x[MAX_HANDLES];
   int               handle_y[MAX_HANDLES];
   int               handles_stored;
   int               half_width;
   bit               box_filter;
   rsp_type          expected_rsp_q[$];

   assign pending = expected_rsp_q.size();

   function automatic int cell_key(int cx, int cy);
      int key;
      key = 0;
      for (int b = 0; b < GRID_BITS; b++) begin
         key |= ((cx >> b) & 1) << (2 * b);
         key |= ((cy >> b) & 1) << (2 * b + 1);
      end
      return key;
   endfunction

   function automatic void push_result(int hnd, logic [1:0] st, bit lst);
      rsp_type r;
      r.found_handle = hnd[HANDLE_W-1:0];
      r.status       = st;
      r.last         = lst;
      r.entry_count  = handles_stored[TOTAL_W-1:0];
      expected_rsp_q.insert(expected_rsp_q.size(), r);
   endfunction

   function automatic void predict_request(req_type rq);
      int px, py, cx, cy, hnd, key, fill, cnt, lx, hx, ly, hy;
      logic [1:0] st;
      px  = int'(rq.pos_x);
      py  = int'(rq.pos_y);
      cx  = px >>> FRAC_BITS;
      cy  = py >>> FRAC_BITS;
      hnd = int'(rq.item_handle);
      st  = STATUS_OK;
      if (rq.opcode == OP_INSERT) begin
         if (hnd >= 1 && hnd <= MAX_HANDLES) begin
            if (cx < 0 || cy < 0 || cx >= (1 << GRID_BITS) || cy >= (1 << GRID_BITS)) begin
               st = STATUS_OFFGRID;
            end else begin
               key  = cell_key(cx, cy);
               fill = fill_count[key];
               if (fill >= BUCKET_SLOTS) begin
                  st = STATUS_FULL;
               end else begin
                  bucket_handle[key*BUCKET_SLOTS+fill] = rq.item_handle;
                  fill_count[key] = fill + 1;
                  handle_x[hnd-1] = px;
                  handle_y[hnd-1] = py;
                  handles_stored++;
               end
            end
         end
         push_result(0, st, 1);
      end else if (rq.opcode == OP_CLEAR) begin
         foreach (fill_count[i]) fill_count[i] = 0;
         handles_stored = 0;
         push_result(0, STATUS_OK, 1);
      end else if (rq.opcode == OP_QUERY) begin
         cnt = 0;
         lx  = ((cx << FRAC_BITS) - half_width) >>> FRAC_BITS;
         hx  = ((cx << FRAC_BITS) + half_width) >>> FRAC_BITS;
         ly  = ((cy << FRAC_BITS) - half_width) >>> FRAC_BITS;
         hy  = ((cy << FRAC_BITS) + half_width) >>> FRAC_BITS;
         for (int x = lx; x <= hx; x++) begin
            if (x < 0 || x >= (1 << GRID_BITS)) continue;
            for (int y = ly; y <= hy; y++) begin
               if (y < 0 || y >= (1 << GRID_BITS)) continue;
               key = cell_key(x, y);
               for (int s = 0; s < fill_count[key]; s++) begin
                  int  h;
                  bit  keep;
                  h    = int'(bucket_handle[key*BUCKET_SLOTS+s]);
                  keep = 1;
                  if (box_filter && h >= 1 && h <= MAX_HANDLES) begin
                     if (handle_x[h-1] < px - half_width || handle_y[h-1] < py - half_width ||
                         handle_x[h-1] > px + half_width || handle_y[h-1] > py + half_width)
                        keep = 0;
                  end
                  if (keep && cnt < RESULT_CAP) begin
                     push_result(h, STATUS_OK, 0);
                     cnt++;
                  end
               end
            end
         end
         if (cnt == 0) push_result(0, STATUS_OK, 1);
         else expected_rsp_q[$].last = 1'b1;
      end else begin
         push_result(0, STATUS_OK, 1);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (fill_count[i]) fill_count[i] = 0;
         handles_stored = 0;
         half_width     = RANGE_RESET;
         box_filter     = 0;
         fail_count     = 0;
         results_seen   = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsp_q.pop_front();
               if (rsp_data.found_handle !== e.found_handle || rsp_data.status !== e.status ||
                   rsp_data.last !== e.last || rsp_data.entry_count !== e.entry_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p got %p", e, rsp_data);
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SEARCH_RANGE) half_width = int'(csr_wdata[RANGE_W-1:0]);
            else if (csr_index == CSR_EXACT_FILTER) box_filter = csr_wdata[0];
         end
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
// top of the spatial hash grid testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb;
   import shg_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    results_seen;
   int                    send_idle;
   int                    recv_idle;
   int                    requests_sent;
   int                    queries_sent;

   spatial_hash_grid_range_query_top dut (.*);

   shg_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_request(logic [1:0] op, int x, int y, int hnd);
      int gap;
      gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, pos_x: x[POS_W-1:0], pos_y: y[POS_W-1:0],
                     item_handle: hnd[HANDLE_W-1:0]};
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      requests_sent++;
      if (op == OP_QUERY) queries_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      forever begin
         @(negedge clock);
         if (pending == 0) break;
      end
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_requests(int n);
      int sel, x, y;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 85) begin
            x = $urandom_range(0, 8 * 16 - 1);
            y = $urandom_range(0, 8 * 16 - 1);
         end else begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
            x = (x > 32767) ? x - 65536 : x;
            y = (y > 32767) ? y - 65536 : y;
         end
         sel = $urandom_range(99);
         if (sel < 55)
            send_request(OP_INSERT, x, y,
                         ($urandom_range(19) == 0) ? $urandom_range(0, 2047)
                                                   : $urandom_range(1, 1024));
         else if (sel < 97)
            send_request(OP_QUERY, x, y, $urandom_range(0, 2047));
         else
            send_request(2'd3, x, y, $urandom_range(0, 2047));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle     = 8;
      recv_idle     = 54;
      requests_sent = 0;
      queries_sent  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: default range, no filter, then exact filter with range 28
      send_request(OP_INSERT, 0, 0, 1);
      send_request(OP_INSERT, 1023, 1023, 1024);
      send_request(OP_INSERT, -1, 5, 2);
      send_request(OP_INSERT, 5, 1024, 3);
      send_request(OP_INSERT, 32767, -32768, 4);
      send_request(OP_INSERT, 8, 8, 0);
      send_request(OP_INSERT, 8, 8, 1025);
      send_request(OP_INSERT, 8, 8, 2047);
      for (int i = 0; i < 5; i++) send_request(OP_INSERT, 20 + i, 20, 10 + i);
      send_request(OP_INSERT, 40, 40, 1);
      send_request(OP_QUERY, 0, 0, 0);
      send_request(OP_QUERY, 24, 24, 0);
      send_request(OP_QUERY, 1023, 1023, 0);
      send_request(OP_QUERY, -32768, -32768, 0);
      send_request(OP_QUERY, 32767, 32767, 0);
      send_request(2'd3, -1, -1, 2047);
      wait_idle();
      write_csr(CSR_EXACT_FILTER, 1);
      write_csr(CSR_SEARCH_RANGE, 28);
      send_request(OP_QUERY, 20, 20, 0);
      send_request(OP_QUERY, 60, 60, 0);
      send_request(OP_CLEAR, 0, 0, 0);
      send_request(OP_QUERY, 20, 20, 0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 8 : (phase == 1) ? 54 : 0;
         recv_idle = (phase == 0) ? 54 : (phase == 1) ? 8 : 0;
         for (int sub = 0; sub < 3; sub++) begin
            wait_idle();
            write_csr(CSR_SEARCH_RANGE, (sub == 0) ? 0 : (sub == 1) ? 28 : $urandom_range(0, 28));
            write_csr(CSR_EXACT_FILTER, $urandom_range(1));
            random_requests(42);
         end
         send_request(OP_CLEAR, 0, 0, 0);
      end

      wait_idle();
      $display("sent %0d requests (%0d queries), checked %0d results",
               requests_sent, queries_sent, results_seen);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
